// ===== rtl/core/box_mesh_global_numbering_defines.svh =====
`ifndef BOX_MESH_GLOBAL_NUMBERING_DEFINES_SVH
`define BOX_MESH_GLOBAL_NUMBERING_DEFINES_SVH

// Assertion shorthands. clk and rst_n must be visible where they are used.

// cons must hold in the same cycle as ante
`define BMGN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define BMGN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bmgn_pkg.sv =====
`default_nettype none

package bmgn_pkg;

  // field widths
  localparam int PT_W       = 4;
  localparam int ELEM_W     = 11;
  localparam int ELOC_W     = 21;
  localparam int EGLB_W     = 31;
  localparam int LAYER_W    = 3;
  localparam int LI_W       = 30;
  localparam int GN_W       = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam int MAX_POINTS   = 8;
  localparam int MAX_ELEMENTS = 1048576;

  // internal widths
  localparam int P_W       = $clog2(MAX_POINTS);          // order p and point counters
  localparam int NXY_W     = 2 * ELEM_W;
  localparam int TOT_W     = 3 * ELEM_W;
  localparam int DIV_STEPS = EGLB_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int ELM1_W    = $clog2(MAX_ELEMENTS);        // elem_local - 1
  localparam int SX_W      = P_W + ELEM_W;                // p*elems + 1
  localparam int SXY_W     = 2 * SX_W;
  localparam int KG_W      = P_W + EGLB_W;                // p*(ez-1) + k
  localparam int KG_SPLIT  = 16;
  localparam int GN_HI_W   = GN_W - KG_SPLIT;
  localparam int PXY_W     = 2 * PT_W;
  localparam int PXYZ_W    = 3 * PT_W;
  localparam int PXYK_W    = PXY_W + LAYER_W;

  localparam logic [PT_W-1:0]   PTS_MIN  = PT_W'(2);
  localparam logic [PT_W-1:0]   PTS_MAX  = PT_W'(MAX_POINTS);
  localparam logic [ELOC_W-1:0] ELOC_MAX = ELOC_W'(MAX_ELEMENTS);

  localparam logic [PT_W-1:0]   PTS_RST  = PT_W'(4);
  localparam logic [ELEM_W-1:0] ELEM_RST = ELEM_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINTS_X = 3'd0,
    REG_POINTS_Y = 3'd1,
    REG_POINTS_Z = 3'd2,
    REG_ELEMS_X  = 3'd3,
    REG_ELEMS_Y  = 3'd4,
    REG_ELEMS_Z  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [PT_W-1:0]   points_x;
    logic [PT_W-1:0]   points_y;
    logic [PT_W-1:0]   points_z;
    logic [ELEM_W-1:0] elems_x;
    logic [ELEM_W-1:0] elems_y;
    logic [ELEM_W-1:0] elems_z;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NXY,
    S_TOTAL,
    S_CHECK,
    S_DIV1,
    S_DIV1_WAIT,
    S_DIV2,
    S_DIV2_WAIT,
    S_CALC1,
    S_CALC2,
    S_CALC3,
    S_CALC4,
    S_CALC5,
    S_EMIT,
    S_ERR
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_NXY,
    OP_TOTAL,
    OP_DIV1,
    OP_DIV1_END,
    OP_DIV2,
    OP_DIV2_END,
    OP_CALC1,
    OP_CALC2,
    OP_CALC3,
    OP_CALC4,
    OP_CALC5,
    OP_EMIT,
    OP_ERR
  } dp_op_t;

  typedef struct packed {
    logic bad;        // item or points_x is out of range
    logic div_done;   // divider holds a finished result
    logic out_free;   // output register can take a beat this cycle
    logic last_pt;    // current point is the final one of the layer
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/bmgn_in_if.sv =====
`default_nettype none

interface bmgn_in_if;
  logic                          valid;
  logic                          ready;
  logic [bmgn_pkg::ELOC_W-1:0]   elem_local;
  logic [bmgn_pkg::EGLB_W-1:0]   elem_global;
  logic [bmgn_pkg::LAYER_W-1:0]  layer;

  modport source (output valid, output elem_local, output elem_global, output layer,
                  input ready);
  modport sink   (input valid, input elem_local, input elem_global, input layer,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bmgn_out_if.sv =====
`default_nettype none

interface bmgn_out_if;
  logic                       valid;
  logic                       ready;
  logic [bmgn_pkg::LI_W-1:0]  local_index;
  logic [bmgn_pkg::GN_W-1:0]  global_number;
  logic                       last;
  logic                       error;

  modport source (output valid, output local_index, output global_number, output last,
                  output error, input ready);
  modport sink   (input valid, input local_index, input global_number, input last,
                  input error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bmgn_cfg_if.sv =====
`default_nettype none

interface bmgn_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bmgn_pkg::CFG_IDX_W-1:0]   index;
  logic [bmgn_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bmgn_cfg.sv =====
`default_nettype none

module bmgn_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bmgn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bmgn_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bmgn_pkg::cfg_t                   cfg
);

  bmgn_pkg::cfg_t cfg_r;
  bmgn_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (bmgn_pkg::cfg_reg_t'(cfg_index))
        bmgn_pkg::REG_POINTS_X: cfg_nxt.points_x = cfg_data[bmgn_pkg::PT_W-1:0];
        bmgn_pkg::REG_POINTS_Y: cfg_nxt.points_y = cfg_data[bmgn_pkg::PT_W-1:0];
        bmgn_pkg::REG_POINTS_Z: cfg_nxt.points_z = cfg_data[bmgn_pkg::PT_W-1:0];
        bmgn_pkg::REG_ELEMS_X:  cfg_nxt.elems_x  = cfg_data[bmgn_pkg::ELEM_W-1:0];
        bmgn_pkg::REG_ELEMS_Y:  cfg_nxt.elems_y  = cfg_data[bmgn_pkg::ELEM_W-1:0];
        bmgn_pkg::REG_ELEMS_Z:  cfg_nxt.elems_z  = cfg_data[bmgn_pkg::ELEM_W-1:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.points_x <= bmgn_pkg::PTS_RST;
      cfg_r.points_y <= bmgn_pkg::PTS_RST;
      cfg_r.points_z <= bmgn_pkg::PTS_RST;
      cfg_r.elems_x  <= bmgn_pkg::ELEM_RST;
      cfg_r.elems_y  <= bmgn_pkg::ELEM_RST;
      cfg_r.elems_z  <= bmgn_pkg::ELEM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bmgn_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module bmgn_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bmgn_pkg::EGLB_W-1:0]   dividend,
  input  logic [bmgn_pkg::NXY_W-1:0]    divisor,
  output logic [bmgn_pkg::EGLB_W-1:0]   quotient,
  output logic [bmgn_pkg::NXY_W-1:0]    remainder,
  output logic                          done
);

  logic [bmgn_pkg::EGLB_W-1:0] quo_r;
  logic [bmgn_pkg::NXY_W-1:0]  rem_r;
  logic [bmgn_pkg::NXY_W-1:0]  dvs_r;
  logic [bmgn_pkg::DCNT_W-1:0] cnt_r;
  logic                        busy_r;
  logic                        done_r;

  logic [bmgn_pkg::NXY_W:0]    trial;
  logic [bmgn_pkg::NXY_W:0]    diff;
  logic                        fits;
  logic [bmgn_pkg::NXY_W-1:0]  rem_nxt;

  // partial remainder stays below the divisor, so the difference fits NXY_W bits
  assign trial   = {rem_r, quo_r[bmgn_pkg::EGLB_W-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign fits    = (trial >= {1'b0, dvs_r});
  assign rem_nxt = fits ? diff[bmgn_pkg::NXY_W-1:0] : trial[bmgn_pkg::NXY_W-1:0];

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= bmgn_pkg::DCNT_W'(bmgn_pkg::DIV_STEPS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[bmgn_pkg::EGLB_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bmgn_dpath.sv =====
`default_nettype none

module bmgn_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bmgn_pkg::dp_op_t               op,
  output bmgn_pkg::dp_status_t           status,
  input  bmgn_pkg::cfg_t                 cfg,
  input  logic [bmgn_pkg::ELOC_W-1:0]    in_elem_local,
  input  logic [bmgn_pkg::EGLB_W-1:0]    in_elem_global,
  input  logic [bmgn_pkg::LAYER_W-1:0]   in_layer,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bmgn_pkg::LI_W-1:0]      out_local_index,
  output logic [bmgn_pkg::GN_W-1:0]      out_global_number,
  output logic                           out_last,
  output logic                           out_error
);

  localparam int ELOC_W  = bmgn_pkg::ELOC_W;
  localparam int EGLB_W  = bmgn_pkg::EGLB_W;
  localparam int LAYER_W = bmgn_pkg::LAYER_W;
  localparam int ELEM_W  = bmgn_pkg::ELEM_W;
  localparam int PT_W    = bmgn_pkg::PT_W;
  localparam int P_W     = bmgn_pkg::P_W;
  localparam int NXY_W   = bmgn_pkg::NXY_W;
  localparam int TOT_W   = bmgn_pkg::TOT_W;
  localparam int ELM1_W  = bmgn_pkg::ELM1_W;
  localparam int SX_W    = bmgn_pkg::SX_W;
  localparam int SXY_W   = bmgn_pkg::SXY_W;
  localparam int KG_W    = bmgn_pkg::KG_W;
  localparam int KG_SPL  = bmgn_pkg::KG_SPLIT;
  localparam int GN_HI_W = bmgn_pkg::GN_HI_W;
  localparam int PXY_W   = bmgn_pkg::PXY_W;
  localparam int PXYZ_W  = bmgn_pkg::PXYZ_W;
  localparam int PXYK_W  = bmgn_pkg::PXYK_W;
  localparam int LI_W    = bmgn_pkg::LI_W;
  localparam int GN_W    = bmgn_pkg::GN_W;

  // captured item
  logic [ELOC_W-1:0]  el_r;
  logic [EGLB_W-1:0]  eg_r;
  logic [LAYER_W-1:0] k_r;

  // element setup
  logic [NXY_W-1:0]   nxy_r;
  logic [TOT_W-1:0]   total_r;
  logic [EGLB_W-1:0]  ez1_r;
  logic [NXY_W-1:0]   rem1_r;
  logic [ELEM_W-1:0]  ey1_r;
  logic [ELEM_W-1:0]  ex1_r;
  logic [SX_W-1:0]    sx_r;
  logic [SX_W-1:0]    sy_r;
  logic [KG_W-1:0]    kg_r;
  logic [SX_W-1:0]    igb_r;
  logic [SX_W-1:0]    pey_r;
  logic [PXY_W-1:0]   pxy_r;
  logic [ELM1_W-1:0]  el1_r;
  logic [SXY_W-1:0]   sxy_r;
  logic [SXY_W-1:0]   jgs_r;
  logic [PXYK_W-1:0]  pxyk_r;
  logic [PXYZ_W-1:0]  pxyz_r;
  logic [GN_W-1:0]    plo_r;
  logic [GN_HI_W-1:0] phi_r;
  logic [LI_W-1:0]    lie_r;
  logic [GN_W-1:0]    gacc_r;
  logic [LI_W-1:0]    lbase_r;

  // point walk
  logic [P_W-1:0]     i_r;
  logic [P_W-1:0]     j_r;
  logic [LI_W-1:0]    row_l_r;
  logic [LI_W-1:0]    cur_l_r;
  logic [GN_W-1:0]    row_g_r;
  logic [GN_W-1:0]    cur_g_r;

  // output register
  logic               out_valid_r;
  logic [LI_W-1:0]    out_li_r;
  logic [GN_W-1:0]    out_gn_r;
  logic               out_last_r;
  logic               out_err_r;

  // combinational terms
  logic [PT_W-1:0]    pm1;
  logic [P_W-1:0]     p_w;
  logic [EGLB_W-1:0]  g1_w;
  logic [ELOC_W-1:0]  el1_w;
  logic [TOT_W-1:0]   total_w;
  logic [NXY_W-1:0]   nxy_w;
  logic [SX_W-1:0]    sx_w;
  logic [SX_W-1:0]    sy_w;
  logic [KG_W-1:0]    kg_w;
  logic [SX_W-1:0]    igb_w;
  logic [SX_W-1:0]    pey_w;
  logic [PXY_W-1:0]   pxy_w;
  logic [SXY_W-1:0]   sxy_w;
  logic [SXY_W-1:0]   jgs_w;
  logic [PXYK_W-1:0]  pxyk_w;
  logic [PXYZ_W-1:0]  pxyz_w;
  logic [KG_SPL+SXY_W-1:0]      plo_w;
  logic [KG_W-KG_SPL+SXY_W-1:0] phi_w;
  logic [PXYZ_W+ELM1_W-1:0]     lie_w;
  logic [GN_W-1:0]    gbase_w;
  logic [LI_W-1:0]    row_l_nxt;
  logic [GN_W-1:0]    row_g_nxt;
  logic               row_end;
  logic               last_pt;
  logic               out_free;

  logic               div_start;
  logic [EGLB_W-1:0]  div_dividend;
  logic [NXY_W-1:0]   div_divisor;
  logic [EGLB_W-1:0]  div_quo;
  logic [NXY_W-1:0]   div_rem;
  logic               div_done;

  assign pm1     = cfg.points_x - 1'b1;
  assign p_w     = pm1[P_W-1:0];
  assign g1_w    = eg_r - 1'b1;
  assign el1_w   = el_r - 1'b1;

  assign nxy_w   = cfg.elems_x * cfg.elems_y;
  assign total_w = nxy_r * cfg.elems_z;

  assign sx_w    = p_w * cfg.elems_x + 1'b1;
  assign sy_w    = p_w * cfg.elems_y + 1'b1;
  assign kg_w    = p_w * ez1_r + k_r;
  assign igb_w   = p_w * ex1_r;
  assign pey_w   = p_w * ey1_r;
  assign pxy_w   = cfg.points_x * cfg.points_y;

  assign sxy_w   = sx_r * sy_r;
  assign jgs_w   = pey_r * sx_r;
  assign pxyk_w  = pxy_r * k_r;
  assign pxyz_w  = pxy_r * cfg.points_z;

  // kg * sx * sy is only needed mod 2^GN_W: split kg into two partial products
  assign plo_w   = kg_r[KG_SPL-1:0] * sxy_r;
  assign phi_w   = kg_r[KG_W-1:KG_SPL] * sxy_r;
  assign lie_w   = pxyz_r * el1_r;

  assign gbase_w = gacc_r + igb_r + jgs_r + 1'b1;

  assign row_l_nxt = row_l_r + cfg.points_x;
  assign row_g_nxt = row_g_r + sx_r;
  assign row_end   = (i_r == p_w);
  assign last_pt   = row_end && (j_r == p_w);
  assign out_free  = !out_valid_r || out_ready;

  assign div_start    = (op == bmgn_pkg::OP_DIV1) || (op == bmgn_pkg::OP_DIV2);
  assign div_dividend = (op == bmgn_pkg::OP_DIV1) ? g1_w
                                                   : {{(EGLB_W-NXY_W){1'b0}}, rem1_r};
  assign div_divisor  = (op == bmgn_pkg::OP_DIV1) ? nxy_r
                                                   : {{(NXY_W-ELEM_W){1'b0}}, cfg.elems_x};

  bmgn_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  always_comb begin
    status.bad = (cfg.points_x < bmgn_pkg::PTS_MIN) || (cfg.points_x > bmgn_pkg::PTS_MAX) ||
                 (eg_r == '0) || ({{(TOT_W-EGLB_W){1'b0}}, eg_r} > total_r) ||
                 (el_r == '0) || (el_r > bmgn_pkg::ELOC_MAX) ||
                 ({1'b0, k_r} >= cfg.points_x);
    status.div_done = div_done;
    status.out_free = out_free;
    status.last_pt  = last_pt;
  end

  always_ff @(posedge clk) begin
    case (op)
      bmgn_pkg::OP_CAPTURE: begin
        el_r <= in_elem_local;
        eg_r <= in_elem_global;
        k_r  <= in_layer;
      end
      bmgn_pkg::OP_NXY:      nxy_r   <= nxy_w;
      bmgn_pkg::OP_TOTAL:    total_r <= total_w;
      bmgn_pkg::OP_DIV1_END: begin
        ez1_r  <= div_quo;
        rem1_r <= div_rem;
      end
      bmgn_pkg::OP_DIV2_END: begin
        ey1_r <= div_quo[ELEM_W-1:0];
        ex1_r <= div_rem[ELEM_W-1:0];
      end
      bmgn_pkg::OP_CALC1: begin
        sx_r  <= sx_w;
        sy_r  <= sy_w;
        kg_r  <= kg_w;
        igb_r <= igb_w;
        pey_r <= pey_w;
        pxy_r <= pxy_w;
        el1_r <= el1_w[ELM1_W-1:0];
      end
      bmgn_pkg::OP_CALC2: begin
        sxy_r  <= sxy_w;
        jgs_r  <= jgs_w;
        pxyk_r <= pxyk_w;
        pxyz_r <= pxyz_w;
      end
      bmgn_pkg::OP_CALC3: begin
        plo_r <= plo_w[GN_W-1:0];
        phi_r <= phi_w[GN_HI_W-1:0];
        lie_r <= lie_w[LI_W-1:0];
      end
      bmgn_pkg::OP_CALC4: begin
        gacc_r  <= plo_r + {phi_r, {KG_SPL{1'b0}}};
        lbase_r <= lie_r + pxyk_r + 1'b1;
      end
      bmgn_pkg::OP_CALC5: begin
        i_r     <= '0;
        j_r     <= '0;
        row_l_r <= lbase_r;
        cur_l_r <= lbase_r;
        row_g_r <= gbase_w;
        cur_g_r <= gbase_w;
      end
      bmgn_pkg::OP_EMIT: begin
        if (row_end) begin
          i_r     <= '0;
          j_r     <= j_r + 1'b1;
          row_l_r <= row_l_nxt;
          cur_l_r <= row_l_nxt;
          row_g_r <= row_g_nxt;
          cur_g_r <= row_g_nxt;
        end else begin
          i_r     <= i_r + 1'b1;
          cur_l_r <= cur_l_r + 1'b1;
          cur_g_r <= cur_g_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register; a beat is loaded only when the slot is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == bmgn_pkg::OP_EMIT || op == bmgn_pkg::OP_ERR) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == bmgn_pkg::OP_EMIT) begin
      out_li_r   <= cur_l_r;
      out_gn_r   <= cur_g_r;
      out_last_r <= last_pt;
      out_err_r  <= 1'b0;
    end else if (op == bmgn_pkg::OP_ERR) begin
      out_li_r   <= '0;
      out_gn_r   <= '0;
      out_last_r <= 1'b1;
      out_err_r  <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_local_index   = out_li_r;
  assign out_global_number = out_gn_r;
  assign out_last          = out_last_r;
  assign out_error         = out_err_r;

endmodule

`default_nettype wire

// ===== rtl/core/bmgn_ctrl.sv =====
`default_nettype none

module bmgn_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bmgn_pkg::dp_status_t  status,
  output bmgn_pkg::dp_op_t      op
);

  bmgn_pkg::ctrl_state_t state_r;
  bmgn_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmgn_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bmgn_pkg::S_IDLE:      if (in_valid) state_nxt = bmgn_pkg::S_NXY;
      bmgn_pkg::S_NXY:       state_nxt = bmgn_pkg::S_TOTAL;
      bmgn_pkg::S_TOTAL:     state_nxt = bmgn_pkg::S_CHECK;
      bmgn_pkg::S_CHECK:     state_nxt = status.bad ? bmgn_pkg::S_ERR : bmgn_pkg::S_DIV1;
      bmgn_pkg::S_DIV1:      state_nxt = bmgn_pkg::S_DIV1_WAIT;
      bmgn_pkg::S_DIV1_WAIT: if (status.div_done) state_nxt = bmgn_pkg::S_DIV2;
      bmgn_pkg::S_DIV2:      state_nxt = bmgn_pkg::S_DIV2_WAIT;
      bmgn_pkg::S_DIV2_WAIT: if (status.div_done) state_nxt = bmgn_pkg::S_CALC1;
      bmgn_pkg::S_CALC1:     state_nxt = bmgn_pkg::S_CALC2;
      bmgn_pkg::S_CALC2:     state_nxt = bmgn_pkg::S_CALC3;
      bmgn_pkg::S_CALC3:     state_nxt = bmgn_pkg::S_CALC4;
      bmgn_pkg::S_CALC4:     state_nxt = bmgn_pkg::S_CALC5;
      bmgn_pkg::S_CALC5:     state_nxt = bmgn_pkg::S_EMIT;
      bmgn_pkg::S_EMIT:      if (status.out_free && status.last_pt) state_nxt = bmgn_pkg::S_IDLE;
      bmgn_pkg::S_ERR:       if (status.out_free) state_nxt = bmgn_pkg::S_IDLE;
      default:               state_nxt = bmgn_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    op       = bmgn_pkg::OP_NONE;
    case (state_r)
      bmgn_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = bmgn_pkg::OP_CAPTURE;
      end
      bmgn_pkg::S_NXY:       op = bmgn_pkg::OP_NXY;
      bmgn_pkg::S_TOTAL:     op = bmgn_pkg::OP_TOTAL;
      bmgn_pkg::S_CHECK:     op = bmgn_pkg::OP_NONE;
      bmgn_pkg::S_DIV1:      op = bmgn_pkg::OP_DIV1;
      bmgn_pkg::S_DIV1_WAIT: if (status.div_done) op = bmgn_pkg::OP_DIV1_END;
      bmgn_pkg::S_DIV2:      op = bmgn_pkg::OP_DIV2;
      bmgn_pkg::S_DIV2_WAIT: if (status.div_done) op = bmgn_pkg::OP_DIV2_END;
      bmgn_pkg::S_CALC1:     op = bmgn_pkg::OP_CALC1;
      bmgn_pkg::S_CALC2:     op = bmgn_pkg::OP_CALC2;
      bmgn_pkg::S_CALC3:     op = bmgn_pkg::OP_CALC3;
      bmgn_pkg::S_CALC4:     op = bmgn_pkg::OP_CALC4;
      bmgn_pkg::S_CALC5:     op = bmgn_pkg::OP_CALC5;
      bmgn_pkg::S_EMIT:      if (status.out_free) op = bmgn_pkg::OP_EMIT;
      bmgn_pkg::S_ERR:       if (status.out_free) op = bmgn_pkg::OP_ERR;
      default:               op = bmgn_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/box_mesh_global_numbering.sv =====
// Channel | Dir | Payload                                          | Handshake
// in_ch   | in  | elem_local, elem_global, layer                   | valid/ready
// out_ch  | out | local_index, global_number, last, error          | valid/ready
// cfg_ch  | in  | index (register 0..5), data                      | valid/ready, ready always high
//
// One item at a time: a good item gives points_x^2 beats after two 31-step divisions
// in the shared restoring divider; an error item skips the divisions and shows its one
// beat. Beats leave one per cycle when out_ch.ready holds.
// Synchronous active-low reset; registers return to points 4/4/4 and elems 1/1/1.
// A stalled result stays in the output register; the next item is taken once the
// final beat of the current one is loaded there.
`default_nettype none

module box_mesh_global_numbering (
  input  logic            clk,
  input  logic            rst_n,
  bmgn_in_if.sink         in_ch,
  bmgn_out_if.source      out_ch,
  bmgn_cfg_if.sink        cfg_ch
);

  bmgn_pkg::cfg_t        cfg;
  bmgn_pkg::dp_op_t      op;
  bmgn_pkg::dp_status_t  status;

  bmgn_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .cfg       (cfg)
  );

  bmgn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .op       (op)
  );

  bmgn_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (op),
    .status            (status),
    .cfg               (cfg),
    .in_elem_local     (in_ch.elem_local),
    .in_elem_global    (in_ch.elem_global),
    .in_layer          (in_ch.layer),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_local_index   (out_ch.local_index),
    .out_global_number (out_ch.global_number),
    .out_last          (out_ch.last),
    .out_error         (out_ch.error)
  );

endmodule

`default_nettype wire

// ===== rtl/core/bmgn_chk.sv =====
`default_nettype none

`include "box_mesh_global_numbering_defines.svh"

module bmgn_chk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [bmgn_pkg::LI_W-1:0]     out_local_index,
  input  logic [bmgn_pkg::GN_W-1:0]     out_global_number,
  input  logic                          out_last,
  input  logic                          out_error
);

  logic                                     in_beat;
  logic                                     out_stall;
  logic [bmgn_pkg::LI_W+bmgn_pkg::GN_W+1:0] out_word;
  logic                                     err_shape;

  assign in_beat    = in_valid && in_ready;
  assign out_stall  = out_valid && !out_ready;
  assign out_word   = {out_local_index, out_global_number, out_last, out_error};
  assign err_shape  = out_last && (out_local_index == '0) && (out_global_number == '0);

  `BMGN_ASSERT_NEXT(a_busy_after_accept, in_beat, !in_ready, "input taken while busy")
  `BMGN_ASSERT_NOW(a_error_beat, out_valid && out_error, err_shape, "bad error beat")
  `BMGN_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "beat changed in stall")
  `BMGN_ASSERT_NOW(a_out_drop, $fell(out_valid) && $past(rst_n), $past(out_ready), "beat dropped")

endmodule

bind box_mesh_global_numbering bmgn_chk u_bmgn_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_local_index   (out_ch.local_index),
  .out_global_number (out_ch.global_number),
  .out_last          (out_ch.last),
  .out_error         (out_ch.error)
);

`default_nettype wire

// ===== tb/box_mesh_global_numbering_test.sv =====
`timescale 1ns / 1ps

module box_mesh_global_numbering_test;
  import bmgn_pkg::*;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_ITEMS   = 40;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [EGLB_W-1:0] EG_TOP  = {EGLB_W{1'b1}};
  localparam logic [ELOC_W-1:0] EL_TOP  = {ELOC_W{1'b1}};
  localparam logic [EGLB_W-1:0] EG_2P30 = EGLB_W'(64'h4000_0000);

  typedef enum logic [2:0] {
    ACT_ITEM,
    ACT_CFG,
    ACT_MODE,
    ACT_HOLD,
    ACT_DRAIN
  } act_kind_t;

  typedef struct {
    act_kind_t               kind;
    logic [ELOC_W-1:0]       elem_local;
    logic [EGLB_W-1:0]       elem_global;
    logic [LAYER_W-1:0]      layer;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    int                      idle_pct;
    int                      stall_pct;
  } action_t;

  typedef struct packed {
    logic [LI_W-1:0] local_index;
    logic [GN_W-1:0] global_number;
    logic            last;
    logic            error;
  } point_t;

  logic clk;
  logic rst_n;

  bmgn_in_if  in_bus ();
  bmgn_out_if out_bus ();
  bmgn_cfg_if cfg_bus ();

  box_mesh_global_numbering u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  action_t action_q[$];
  point_t  pending_points[$];

  // register copy seen by the predictor, updated on accepted config beats
  logic [PT_W-1:0]   cfg_px, cfg_py, cfg_pz;
  logic [ELEM_W-1:0] cfg_nx, cfg_ny, cfg_nz;

  // register copy used while building the stimulus
  int plan_px, plan_py, plan_pz, plan_nx, plan_ny, plan_nz;

  int   idle_pct;
  int   stall_pct;
  int   settle_left;
  int   hold_left;
  int   fail_count;
  int   cycle_count;
  logic hold_go;
  logic all_done;

  logic    in_busy, cfg_busy, next_in, next_cfg, pulse;
  action_t act;
  point_t  want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic action_t make_action(act_kind_t kind, logic [ELOC_W-1:0] el,
                                          logic [EGLB_W-1:0] eg, logic [LAYER_W-1:0] k,
                                          logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data, int idle, int stall);
    action_t a;
    a.kind        = kind;
    a.elem_local  = el;
    a.elem_global = eg;
    a.layer       = k;
    a.cfg_index   = idx;
    a.cfg_data    = data;
    a.idle_pct    = idle;
    a.stall_pct   = stall;
    return a;
  endfunction

  task automatic push_item(input logic [ELOC_W-1:0] el, input logic [EGLB_W-1:0] eg,
                           input logic [LAYER_W-1:0] k);
    action_q.push_back(make_action(ACT_ITEM, el, eg, k, '0, '0, 0, 0));
  endtask

  task automatic push_mode(input int idle, input int stall);
    action_q.push_back(make_action(ACT_MODE, '0, '0, '0, '0, '0, idle, stall));
  endtask

  task automatic push_drain();
    action_q.push_back(make_action(ACT_DRAIN, '0, '0, '0, '0, '0, 0, 0));
  endtask

  task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    action_q.push_back(make_action(ACT_CFG, '0, '0, '0, idx, data, 0, 0));
    case (idx)
      REG_POINTS_X: plan_px = data[PT_W-1:0];
      REG_POINTS_Y: plan_py = data[PT_W-1:0];
      REG_POINTS_Z: plan_pz = data[PT_W-1:0];
      REG_ELEMS_X:  plan_nx = data[ELEM_W-1:0];
      REG_ELEMS_Y:  plan_ny = data[ELEM_W-1:0];
      REG_ELEMS_Z:  plan_nz = data[ELEM_W-1:0];
      default: ;
    endcase
  endtask

  // point counts sit in the low nibble; the rest of the word is junk the block drops
  function automatic logic [CFG_DATA_W-1:0] pts_word(int pts);
    logic [CFG_DATA_W-1:0] w;
    w = CFG_DATA_W'($urandom);
    w[PT_W-1:0] = PT_W'(pts);
    return w;
  endfunction

  task automatic set_config(input int px, input int py, input int pz,
                            input int nx, input int ny, input int nz);
    push_drain();
    push_cfg(REG_POINTS_X, pts_word(px));
    push_cfg(REG_SPARE_LO, CFG_DATA_W'($urandom));
    push_cfg(REG_POINTS_Y, pts_word(py));
    push_cfg(REG_POINTS_Z, pts_word(pz));
    push_cfg(REG_SPARE_HI, CFG_DATA_W'($urandom));
    push_cfg(REG_ELEMS_X, CFG_DATA_W'(nx));
    push_cfg(REG_ELEMS_Y, CFG_DATA_W'(ny));
    push_cfg(REG_ELEMS_Z, CFG_DATA_W'(nz));
  endtask

  function automatic int pick_elem_count();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(1, 8);
      6, 7:             return $urandom_range(1, 1024);
      8:                return 1024;
      default:          return $urandom_range(0, 2047);
    endcase
  endfunction

  task automatic number_layer_points(input logic [ELOC_W-1:0] el_in,
                                     input logic [EGLB_W-1:0] eg_in,
                                     input logic [LAYER_W-1:0] k_in);
    logic [63:0] px, py, pz, nx, ny, nz, el, eg, k;
    logic [63:0] nxy, total, p, ex, ey, ez, sx, sy, kg, li_base, ig, jg, li, gn;
    point_t      pt;
    int          i, j, cnt;
    px = 64'(cfg_px);
    py = 64'(cfg_py);
    pz = 64'(cfg_pz);
    nx = 64'(cfg_nx);
    ny = 64'(cfg_ny);
    nz = 64'(cfg_nz);
    el = 64'(el_in);
    eg = 64'(eg_in);
    k  = 64'(k_in);
    nxy   = nx * ny;
    total = nxy * nz;
    if (px < 2 || px > MAX_POINTS || eg == 0 || eg > total || el == 0 ||
        el > MAX_ELEMENTS || k > px - 1) begin
      pt.local_index   = '0;
      pt.global_number = '0;
      pt.last          = 1'b1;
      pt.error         = 1'b1;
      pending_points.push_back(pt);
    end else begin
      p  = px - 1;
      ez = 1 + (eg - 1) / nxy;
      ey = 1 + ((eg - 1) % nxy) / nx;
      ex = 1 + (eg - 1) % nx;
      sx = p * nx + 1;
      sy = p * ny + 1;
      kg = p * (ez - 1) + k;
      li_base = 1 + px * py * k + px * py * pz * (el - 1);
      cnt = 0;
      for (j = 0; j <= int'(p); j++) begin
        for (i = 0; i <= int'(p); i++) begin
          ig = p * (ex - 1) + 64'(i);
          jg = p * (ey - 1) + 64'(j);
          li = li_base + 64'(i) + px * 64'(j);
          gn = 1 + ig + jg * sx + kg * sx * sy;
          cnt++;
          pt.local_index   = li[LI_W-1:0];
          pt.global_number = gn[GN_W-1:0];
          pt.last          = (64'(cnt) == px * px);
          pt.error         = 1'b0;
          pending_points.push_back(pt);
        end
      end
    end
  endtask

  // driver: one beat in flight on either the item or the config channel
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid  <= 1'b0;
      cfg_bus.valid <= 1'b0;
      hold_go       <= 1'b0;
      all_done      <= 1'b0;
      settle_left   <= 0;
      idle_pct      = 0;
      stall_pct     <= 0;
      cfg_px = PTS_RST;
      cfg_py = PTS_RST;
      cfg_pz = PTS_RST;
      cfg_nx = ELEM_RST;
      cfg_ny = ELEM_RST;
      cfg_nz = ELEM_RST;
    end else begin
      in_busy  = in_bus.valid && !in_bus.ready;
      cfg_busy = cfg_bus.valid && !cfg_bus.ready;
      if (in_bus.valid && in_bus.ready)
        number_layer_points(in_bus.elem_local, in_bus.elem_global, in_bus.layer);
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_POINTS_X: cfg_px = cfg_bus.data[PT_W-1:0];
          REG_POINTS_Y: cfg_py = cfg_bus.data[PT_W-1:0];
          REG_POINTS_Z: cfg_pz = cfg_bus.data[PT_W-1:0];
          REG_ELEMS_X:  cfg_nx = cfg_bus.data[ELEM_W-1:0];
          REG_ELEMS_Y:  cfg_ny = cfg_bus.data[ELEM_W-1:0];
          REG_ELEMS_Z:  cfg_nz = cfg_bus.data[ELEM_W-1:0];
          default: ;
        endcase
      end
      next_in  = in_busy;
      next_cfg = cfg_busy;
      pulse    = 1'b0;
      if (!in_busy && !cfg_busy) begin
        if (settle_left != 0) begin
          settle_left <= settle_left - 1;
        end else if (action_q.size() != 0) begin
          act = action_q[0];
          case (act.kind)
            ACT_ITEM: begin
              if ($urandom_range(0, 99) >= idle_pct) begin
                action_q.delete(0);
                in_bus.elem_local  <= act.elem_local;
                in_bus.elem_global <= act.elem_global;
                in_bus.layer       <= act.layer;
                next_in = 1'b1;
              end
            end
            ACT_CFG: begin
              action_q.delete(0);
              cfg_bus.index <= act.cfg_index;
              cfg_bus.data  <= act.cfg_data;
              next_cfg = 1'b1;
            end
            ACT_MODE: begin
              action_q.delete(0);
              idle_pct = act.idle_pct;
              stall_pct <= act.stall_pct;
            end
            ACT_HOLD: begin
              action_q.delete(0);
              pulse = 1'b1;
            end
            ACT_DRAIN: begin
              // block is idle only once every point of the last item is out
              if (pending_points.size() == 0) begin
                action_q.delete(0);
                settle_left <= SETTLE_CYCLES;
              end
            end
            default: action_q.delete(0);
          endcase
        end else begin
          all_done <= 1'b1;
        end
      end
      in_bus.valid  <= next_in;
      cfg_bus.valid <= next_cfg;
      hold_go       <= pulse;
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_left     <= 0;
    end else begin
      if (hold_go)
        hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
        hold_left <= hold_left - 1;
      out_bus.ready <= !hold_go && hold_left == 0 && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected beat li=%0d gn=%0d last=%0b err=%0b", $time,
                 out_bus.local_index, out_bus.global_number, out_bus.last, out_bus.error);
        fail_count++;
      end else begin
        want = pending_points.pop_front();
        if ({out_bus.local_index, out_bus.global_number, out_bus.last, out_bus.error}
            !== want) begin
          $display("%0t: mismatch exp li=%0d gn=%0d last=%0b err=%0b", $time,
                   want.local_index, want.global_number, want.last, want.error);
          $display("%0t:          got li=%0d gn=%0d last=%0b err=%0b", $time,
                   out_bus.local_index, out_bus.global_number, out_bus.last, out_bus.error);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d points still expected", $time, pending_points.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [63:0]        total, top;
    logic [ELOC_W-1:0]  el;
    logic [EGLB_W-1:0]  eg;
    logic [LAYER_W-1:0] k;
    int                 ph, n, mode;

    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.elem_local  = '0;
    in_bus.elem_global = '0;
    in_bus.layer       = '0;
    out_bus.ready      = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = '0;
    cfg_bus.data       = '0;
    hold_go            = 1'b0;
    all_done           = 1'b0;
    fail_count         = 0;
    cycle_count        = 0;
    plan_px = 4; plan_py = 4; plan_pz = 4;
    plan_nx = 1; plan_ny = 1; plan_nz = 1;

    // directed, reset registers: one element of order 3
    push_mode(0, 0);
    push_item(1, 1, 0);
    push_item(1, 1, 3);
    push_item(7, 1, 4);                    // layer past the order
    push_item(1, 1, 7);
    push_item(1, 0, 0);                    // zero global number
    push_item(1, 2, 0);                    // global number past the box
    push_item(0, 1, 0);                    // zero local number
    push_item(MAX_ELEMENTS, 1, 2);
    push_item(MAX_ELEMENTS + 1, 1, 0);
    push_item(EL_TOP, EG_TOP, 7);

    // largest box, order 7
    set_config(8, 8, 8, 1024, 1024, 1024);
    push_item(MAX_ELEMENTS, EG_2P30, 7);
    push_item(1, 1, 0);
    push_item(5, EG_2P30 + 1, 0);
    push_item(1000, 123456789, 3);

    // local index wraps
    set_config(8, 15, 15, 3, 5, 7);
    push_item(MAX_ELEMENTS, 105, 7);

    // order 1, zero strides, wide x
    set_config(2, 0, 0, 2047, 3, 1);
    push_item(1, 2047 * 3, 1);
    push_item(3, 2047 * 3 + 1, 0);
    push_item(2, 5000, 2);

    // point counts outside the legal order
    set_config(1, 4, 4, 2, 2, 2);
    push_item(1, 1, 0);
    set_config(15, 15, 15, 2, 2, 2);
    push_item(1, 3, 0);
    set_config(0, 1, 1, 2, 2, 2);
    push_item(1, 3, 0);
    set_config(9, 1, 1, 2, 2, 2);
    push_item(1, 3, 0);

    // a zero element count closes the whole box
    set_config(3, 2, 2, 0, 5, 5);
    push_item(1, 1, 0);
    set_config(3, 2, 2, 5, 0, 5);
    push_item(1, 1, 0);
    set_config(3, 2, 2, 5, 5, 0);
    push_item(1, 1, 0);

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      set_config(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 8),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8),
                 pick_elem_count(), pick_elem_count(), pick_elem_count());
      mode = ph % 4;
      case (mode)
        0:       push_mode(0, 0);
        1:       push_mode(87, 0);
        2:       push_mode(0, 87);
        default: push_mode(6, 6);
      endcase
      total = 64'(plan_nx) * 64'(plan_ny) * 64'(plan_nz);
      top   = (total > 64'(EG_TOP)) ? 64'(EG_TOP) : total;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // long output hold-off while items keep coming
        if (ph == 4 && n == 8)
          action_q.push_back(make_action(ACT_HOLD, '0, '0, '0, '0, '0, 0, 0));
        if (n == PHASE_ITEMS / 2 && mode == 3)
          push_drain();
        case ($urandom_range(0, 3))
          0:       el = 1;
          1:       el = MAX_ELEMENTS;
          default: el = $urandom_range(1, MAX_ELEMENTS);
        endcase
        if (top == 0) begin
          eg = $urandom_range(1, 100);
        end else begin
          case ($urandom_range(0, 3))
            0:       eg = 1;
            1:       eg = top[EGLB_W-1:0];
            default: eg = $urandom_range(1, int'(top));
          endcase
        end
        if (plan_px >= 2 && plan_px <= MAX_POINTS)
          k = $urandom_range(0, plan_px - 1);
        else
          k = $urandom_range(0, 7);
        case ($urandom_range(0, 19))
          0: begin
            el = ELOC_W'($urandom);
            eg = EGLB_W'($urandom);
            k  = LAYER_W'($urandom);
          end
          1: if (top < 64'(EG_TOP)) eg = top[EGLB_W-1:0] + 1;
          2: if (plan_px >= 1 && plan_px <= MAX_POINTS - 1) k = plan_px;
          3: el = $urandom_range(MAX_ELEMENTS + 1, int'(EL_TOP));
          default: ;
        endcase
        push_item(el, eg, k);
      end
    end
    push_drain();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (all_done);
    @(posedge clk);
    if (fail_count == 0 && pending_points.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
